@@ hw/rtl/vsr_pkg.sv @@
`default_nettype none
package vsr_pkg;
    localparam int GRID_X = 32;
    localparam int GRID_Y = 32;
    localparam int GRID_Z = 32;
    localparam int XW = 5;
    localparam int YW = 5;
    localparam int ZW = 5;
    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW = XW + YW + ZW;

    localparam logic [3:0] CMD_PUT_VOX = 4'd0;
    localparam logic [3:0] CMD_CUT_VOX = 4'd1;
    localparam logic [3:0] CMD_PUT_BOX = 4'd2;
    localparam logic [3:0] CMD_CUT_BOX = 4'd3;
    localparam logic [3:0] CMD_PUT_SPH = 4'd4;
    localparam logic [3:0] CMD_CUT_SPH = 4'd5;
    localparam logic [3:0] CMD_PUT_ELL = 4'd6;
    localparam logic [3:0] CMD_CUT_ELL = 4'd7;
    localparam logic [3:0] CMD_READ    = 4'd8;

    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;
    localparam logic [1:0] REG_ALPHA = 2'd3;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_SWEEP = 8'b00000100,
        ST_CALC  = 8'b00001000,
        ST_WGHT  = 8'b00010000,
        ST_TEST  = 8'b00100000,
        ST_RDWT  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/voxel_shape_rasterizer_top.sv @@
`default_nettype none
// Voxel grid of 32x32x32 entries (flag plus RGBA) in two RAMs, one for the flags and one
// for the colours, so that a cut clears the flag and keeps the colour.
// After reset a clearing pass over all 32768 entries runs before the first command is taken.
// Single-voxel commands go straight to the output state, a read through a wait state; a box
// steps through each voxel of the box (none if a corner is reversed); spheres and ellipsoids
// sweep the whole grid, each voxel in turn through offset squaring, weighting multiply and
// compare. One command is in work at a time; the result waits in the output register.
module voxel_shape_rasterizer_top
    import vsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[3:0], xa, ya, za, xb, yb, zb, rad_x, rad_y, rad_z (5 bits each), zero pad
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // voxel_on, red, green, blue, alpha, changed_count[15:0], zero pad
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    logic        flag_mem [CELLS];
    logic [31:0] col_mem [CELLS];
    logic [32:0] rd_q;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [32:0] wr_data;
    logic wr_en;
    logic wr_col;

    always_ff @(posedge aclk) begin
        if (wr_en) flag_mem[wr_addr] <= wr_data[32];
        if (wr_en && wr_col) col_mem[wr_addr] <= wr_data[31:0];
        rd_q <= {flag_mem[rd_addr], col_mem[rd_addr]};
    end

    state_t state_reg, state_next;
    logic [7:0] col_reg [4];
    logic [3:0] cmd_reg;
    logic [4:0] xa_reg, ya_reg, za_reg, xb_reg, yb_reg, zb_reg, rx_reg, ry_reg, rz_reg;
    logic [4:0] x_reg, y_reg, z_reg;
    logic [15:0] cnt_reg;
    logic [AW-1:0] clr_reg;
    logic [55:0] out_reg;
    logic ov_reg;
    // per-voxel pipeline registers
    logic [9:0] sx_reg, sy_reg, sz_reg;
    logic [9:0] qx_reg, qy_reg, qz_reg;
    logic [19:0] qyz_reg, qxz_reg, qxy_reg;
    logic [29:0] qxyz_reg;
    logic [31:0] lhs_reg;
    logic hit_ok_reg;

    logic put;
    assign put = ~cmd_reg[0];
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;

    function automatic logic [4:0] adiff(input logic [4:0] a, input logic [4:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [4:0] dx, dy, dz;
    assign dx = adiff(x_reg, xa_reg);
    assign dy = adiff(y_reg, ya_reg);
    assign dz = adiff(z_reg, za_reg);

    logic is_box, last_vox;
    assign is_box = (cmd_reg == CMD_PUT_BOX) || (cmd_reg == CMD_CUT_BOX);
    always_comb begin
        if (is_box) last_vox = (x_reg == xb_reg) && (y_reg == yb_reg) && (z_reg == zb_reg);
        else last_vox = (&x_reg) && (&y_reg) && (&z_reg);
    end

    logic [32:0] fill;
    assign fill = {1'b1, col_reg[0], col_reg[1], col_reg[2], col_reg[3]};

    always_comb begin
        state_next = state_reg;
        wr_en = 1'b0;
        wr_col = put;
        wr_addr = {z_reg, y_reg, x_reg};
        wr_data = put ? fill : 33'd0;
        rd_addr = {s_tdata[18:14], s_tdata[13:9], s_tdata[8:4]};
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                wr_col = 1'b1;
                wr_addr = clr_reg;
                wr_data = 33'd0;
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: if (s_tvalid && s_tready) begin
                unique case (s_tdata[3:0]) inside
                    CMD_PUT_VOX, CMD_CUT_VOX: state_next = ST_OUT;
                    CMD_PUT_BOX, CMD_CUT_BOX: begin
                        if (s_tdata[8:4] <= s_tdata[23:19] && s_tdata[13:9] <= s_tdata[28:24]
                            && s_tdata[18:14] <= s_tdata[33:29])
                            state_next = ST_SWEEP;
                        else state_next = ST_OUT;
                    end
                    CMD_PUT_SPH, CMD_CUT_SPH, CMD_PUT_ELL, CMD_CUT_ELL: state_next = ST_CALC;
                    CMD_READ: state_next = ST_RDWT;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_SWEEP: begin
                // box: every voxel written
                wr_en = 1'b1;
                if (last_vox) state_next = ST_OUT;
            end
            ST_CALC: state_next = ST_WGHT;
            ST_WGHT: state_next = ST_TEST;
            ST_TEST: begin
                wr_en = hit_ok_reg && (lhs_reg <= {2'b0, qxyz_reg});
                if (last_vox) state_next = ST_OUT;
                else state_next = ST_CALC;
            end
            ST_RDWT: begin
                // hold the read address so the data is still valid in the output state
                rd_addr = {za_reg, ya_reg, xa_reg};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (cmd_reg == CMD_PUT_VOX || cmd_reg == CMD_CUT_VOX) wr_en = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // squares and axis weights; sphere uses rad_x on all axes with no zero special case
    logic ell;
    assign ell = cmd_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            col_reg[0] <= 8'd0;
            col_reg[1] <= 8'd0;
            col_reg[2] <= 8'd0;
            col_reg[3] <= 8'd255;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_we) col_reg[cfg_index] <= cfg_wdata;
            if (state_reg == ST_OUT) ov_reg <= 1'b1;
            else if (m_tvalid && m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg <= s_tdata[3:0];
                xa_reg <= s_tdata[8:4];
                ya_reg <= s_tdata[13:9];
                za_reg <= s_tdata[18:14];
                xb_reg <= s_tdata[23:19];
                yb_reg <= s_tdata[28:24];
                zb_reg <= s_tdata[33:29];
                rx_reg <= s_tdata[38:34];
                ry_reg <= s_tdata[43:39];
                rz_reg <= s_tdata[48:44];
                cnt_reg <= '0;
                if (s_tdata[3:0] == CMD_PUT_BOX || s_tdata[3:0] == CMD_CUT_BOX) begin
                    x_reg <= s_tdata[8:4];
                    y_reg <= s_tdata[13:9];
                    z_reg <= s_tdata[18:14];
                end else if (s_tdata[3:0] == CMD_PUT_VOX || s_tdata[3:0] == CMD_CUT_VOX) begin
                    x_reg <= s_tdata[8:4];
                    y_reg <= s_tdata[13:9];
                    z_reg <= s_tdata[18:14];
                end else begin
                    x_reg <= '0;
                    y_reg <= '0;
                    z_reg <= '0;
                end
                // squared axes are fixed for the whole command
                if (s_tdata[1]) begin
                    qx_reg <= (s_tdata[38:34] == 5'd0) ? 10'd1
                              : 10'(s_tdata[38:34]) * 10'(s_tdata[38:34]);
                    qy_reg <= (s_tdata[43:39] == 5'd0) ? 10'd1
                              : 10'(s_tdata[43:39]) * 10'(s_tdata[43:39]);
                    qz_reg <= (s_tdata[48:44] == 5'd0) ? 10'd1
                              : 10'(s_tdata[48:44]) * 10'(s_tdata[48:44]);
                end else begin
                    qx_reg <= 10'd1;
                    qy_reg <= 10'd1;
                    qz_reg <= 10'(s_tdata[38:34]) * 10'(s_tdata[38:34]);
                end
            end
            ST_SWEEP: begin
                cnt_reg <= cnt_reg + 16'd1;
                if (x_reg != xb_reg) x_reg <= x_reg + 5'd1;
                else begin
                    x_reg <= xa_reg;
                    if (y_reg != yb_reg) y_reg <= y_reg + 5'd1;
                    else begin
                        y_reg <= ya_reg;
                        z_reg <= z_reg + 5'd1;
                    end
                end
            end
            ST_CALC: begin
                // squared offsets
                sx_reg <= 10'(dx) * 10'(dx);
                sy_reg <= 10'(dy) * 10'(dy);
                sz_reg <= 10'(dz) * 10'(dz);
                if (ell)
                    hit_ok_reg <= !((rx_reg == 0 && dx != 0) || (ry_reg == 0 && dy != 0)
                                    || (rz_reg == 0 && dz != 0));
                else
                    hit_ok_reg <= 1'b1;
            end
            ST_TEST: begin
                if (wr_en) cnt_reg <= cnt_reg + 16'd1;
                if (x_reg != 5'd31) x_reg <= x_reg + 5'd1;
                else begin
                    x_reg <= '0;
                    if (y_reg != 5'd31) y_reg <= y_reg + 5'd1;
                    else begin
                        y_reg <= '0;
                        z_reg <= z_reg + 5'd1;
                    end
                end
            end
            default: ;
        endcase
        // weight products are registered from the squared axes (qxyz_reg from qxy_reg), each a single multiply
        qyz_reg <= 20'(qy_reg) * 20'(qz_reg);
        qxz_reg <= 20'(qx_reg) * 20'(qz_reg);
        qxy_reg <= 20'(qx_reg) * 20'(qy_reg);
        qxyz_reg <= 30'(qxy_reg) * 30'(qz_reg);
        if (state_reg == ST_WGHT && ell)
            lhs_reg <= 32'(sx_reg) * 32'(qyz_reg) + 32'(sy_reg) * 32'(qxz_reg)
                       + 32'(sz_reg) * 32'(qxy_reg);
        else if (state_reg == ST_WGHT)
            lhs_reg <= 32'(sx_reg) + 32'(sy_reg) + 32'(sz_reg);
        if (state_reg == ST_OUT) begin
            if (cmd_reg == CMD_READ)
                out_reg <= {23'd0, rd_q[0+:8], rd_q[8+:8], rd_q[16+:8], rd_q[24+:8], rd_q[32]};
            else if (cmd_reg == CMD_PUT_VOX || cmd_reg == CMD_CUT_VOX)
                out_reg <= {7'd0, 16'd1, 33'd0};
            else out_reg <= {7'd0, cnt_reg, 33'd0};
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> m_tvalid) else $error("result lost");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !wr_en) else $error("write while idle");
`endif
endmodule
`default_nettype wire

@@ dv/voxel_shape_rasterizer_top_tb.sv @@
`default_nettype none
module voxel_shape_rasterizer_top_tb;
    import vsr_pkg::*;

    localparam logic [3:0] CMD_SPARE_LO = 4'd9;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;
    localparam int STALL_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 80;

    typedef struct packed {
        logic [3:0] cmd;
        logic [4:0] xa, ya, za, xb, yb, zb, rx, ry, rz;
    } voxel_cmd_t;

    typedef struct packed {
        logic        on;
        logic [7:0]  red, green, blue, alpha;
        logic [15:0] changed;
    } voxel_rsp_t;

    typedef struct {
        voxel_cmd_t c;
        bit         typed;
        voxel_rsp_t rsp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;

    always #5 aclk = ~aclk;

    voxel_shape_rasterizer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow of the grid and colour registers
    bit          grid_on  [CELLS];
    logic [31:0] grid_col [CELLS];
    logic [7:0]  paint [4];

    voxel_rsp_t expected_rsp_q[$];
    int errors = 0;
    int items_sent = 0;
    int reads_sent = 0;
    int sweeps_sent = 0;
    int results_seen = 0;
    bit quiet = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        $display("mismatch %0s: expected %0d, got %0d (result %0d)", what, want, got,
                 results_seen);
    endtask

    function automatic int idle_gap();
        if (quiet) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic void paint_cell(int x, int y, int z, bit put, ref int n);
        int i;
        i = (z * GRID_Y + y) * GRID_X + x;
        grid_on[i] = put;
        if (put) grid_col[i] = {paint[0], paint[1], paint[2], paint[3]};
        n++;
    endfunction

    function automatic bit in_ellipsoid(longint dx, longint dy, longint dz,
                                        longint rx, longint ry, longint rz);
        longint qx, qy, qz;
        qx = rx ? rx * rx : 1;
        qy = ry ? ry * ry : 1;
        qz = rz ? rz * rz : 1;
        if ((rx == 0 && dx != 0) || (ry == 0 && dy != 0) || (rz == 0 && dz != 0))
            return 0;
        return dx*dx*qy*qz + dy*dy*qx*qz + dz*dz*qx*qy <= qx*qy*qz;
    endfunction

    // applies one command to the shadow grid and gives the response it must produce
    function automatic voxel_rsp_t rasterize(voxel_cmd_t c);
        voxel_rsp_t r;
        int n;
        int i;
        bit put;
        bit hit;
        longint dx, dy, dz;
        r = '0;
        n = 0;
        put = !c.cmd[0];
        case (c.cmd)
            CMD_PUT_VOX, CMD_CUT_VOX:
                paint_cell(int'(c.xa), int'(c.ya), int'(c.za), put, n);
            CMD_PUT_BOX, CMD_CUT_BOX:
                if (c.xa <= c.xb && c.ya <= c.yb && c.za <= c.zb)
                    for (int z = int'(c.za); z <= int'(c.zb); z++)
                        for (int y = int'(c.ya); y <= int'(c.yb); y++)
                            for (int x = int'(c.xa); x <= int'(c.xb); x++)
                                paint_cell(x, y, z, put, n);
            CMD_PUT_SPH, CMD_CUT_SPH, CMD_PUT_ELL, CMD_CUT_ELL:
                for (int z = 0; z < GRID_Z; z++)
                    for (int y = 0; y < GRID_Y; y++)
                        for (int x = 0; x < GRID_X; x++) begin
                            dx = longint'(x) - longint'(c.xa);
                            dy = longint'(y) - longint'(c.ya);
                            dz = longint'(z) - longint'(c.za);
                            if (c.cmd >= CMD_PUT_ELL)
                                hit = in_ellipsoid(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy,
                                                   dz < 0 ? -dz : dz, longint'(c.rx),
                                                   longint'(c.ry), longint'(c.rz));
                            else
                                hit = dx*dx + dy*dy + dz*dz
                                      <= longint'(c.rx) * longint'(c.rx);
                            if (hit) paint_cell(x, y, z, put, n);
                        end
            CMD_READ: begin
                i = (int'(c.za) * GRID_Y + int'(c.ya)) * GRID_X + int'(c.xa);
                r.on = grid_on[i];
                {r.red, r.green, r.blue, r.alpha} = grid_col[i];
            end
            default: ;
        endcase
        r.changed = n > 65535 ? 16'hffff : n[15:0];
        return r;
    endfunction

    task automatic wait_idle();
        wait (expected_rsp_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_colours(input logic [7:0] r, g, b, a);
        logic [7:0] v [4];
        v = '{r, g, b, a};
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= k[1:0];
            cfg_wdata <= v[k];
            paint[k] = v[k];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send(input voxel_cmd_t c, input bit typed, input voxel_rsp_t want);
        int gap;
        voxel_rsp_t got;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {7'd0, c.rz, c.ry, c.rx, c.zb, c.yb, c.xb, c.za, c.ya, c.xa, c.cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        got = rasterize(c);
        expected_rsp_q.push_back(typed ? want : got);
        items_sent++;
        if (c.cmd == CMD_READ) reads_sent++;
        if (c.cmd inside {[CMD_PUT_SPH:CMD_CUT_ELL]}) sweeps_sent++;
    endtask

    function automatic voxel_cmd_t mk(logic [3:0] cmd, int xa, ya, za, xb = 0, yb = 0,
                                      zb = 0, rx = 0, ry = 0, rz = 0);
        voxel_cmd_t c;
        c = '{cmd, xa[4:0], ya[4:0], za[4:0], xb[4:0], yb[4:0], zb[4:0],
              rx[4:0], ry[4:0], rz[4:0]};
        return c;
    endfunction

    function automatic voxel_rsp_t count_only(int n);
        voxel_rsp_t r;
        r = '0;
        r.changed = n[15:0];
        return r;
    endfunction

    // result side: random back-pressure per transaction
    initial begin
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            n = idle_gap();
            if (n == 0) m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        voxel_rsp_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = {m_tdata[0], m_tdata[8:1], m_tdata[16:9], m_tdata[24:17],
                   m_tdata[32:25], m_tdata[48:33]};
            if (expected_rsp_q.size() == 0)
                report_mismatch("unexpected result", 0, 1);
            else begin
                want = expected_rsp_q.pop_front();
                if (got.on != want.on) report_mismatch("voxel_on", want.on, got.on);
                if (got.red != want.red) report_mismatch("voxel_red", want.red, got.red);
                if (got.green != want.green)
                    report_mismatch("voxel_green", want.green, got.green);
                if (got.blue != want.blue) report_mismatch("voxel_blue", want.blue, got.blue);
                if (got.alpha != want.alpha)
                    report_mismatch("voxel_alpha", want.alpha, got.alpha);
                if (got.changed != want.changed)
                    report_mismatch("changed_count", want.changed, got.changed);
            end
        end
    end

    // watchdog on cycles without any transaction
    int stalled = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stalled <= 0;
        else stalled <= stalled + 1;
        if (stalled >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", stalled);
            $display("voxel_shape_rasterizer_top test failed");
            $finish;
        end
    end

    initial begin
        stim_row_t rows[$];
        voxel_cmd_t c;
        voxel_rsp_t blank;
        voxel_rsp_t rd;
        int pick, lx, ly, lz, w;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        for (int i = 0; i < CELLS; i++) begin
            grid_on[i]  = 0;
            grid_col[i] = '0;
        end
        paint = '{8'd0, 8'd0, 8'd0, 8'd255};
        blank = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // read before any write comes back blank
        send(mk(CMD_READ, 0, 0, 0), 1, blank);
        set_colours(8'd255, 8'd0, 8'h5a, 8'd0);

        rd = '0;
        rd.on = 1;
        {rd.red, rd.green, rd.blue, rd.alpha} = {8'd255, 8'd0, 8'h5a, 8'd0};
        rows.push_back('{mk(CMD_PUT_VOX, 31, 31, 31), 1, count_only(1)});
        rows.push_back('{mk(CMD_READ, 31, 31, 31), 1, rd});
        rows.push_back('{mk(CMD_CUT_VOX, 31, 31, 31), 1, count_only(1)});
        rd.on = 0;
        // a cut keeps the colour
        rows.push_back('{mk(CMD_READ, 31, 31, 31), 1, rd});
        rows.push_back('{mk(CMD_PUT_BOX, 0, 0, 0, 31, 31, 31), 1, count_only(CELLS)});
        rows.push_back('{mk(CMD_CUT_BOX, 9, 2, 2, 4, 30, 30), 1, count_only(0)});
        rows.push_back('{mk(CMD_CUT_BOX, 2, 2, 9, 30, 30, 4), 1, count_only(0)});
        rows.push_back('{mk(CMD_CUT_BOX, 3, 4, 5, 5, 4, 7), 0, blank});
        rows.push_back('{mk(CMD_READ, 4, 4, 6), 0, blank});
        rows.push_back('{mk(CMD_CUT_BOX, 0, 0, 0, 31, 31, 31), 1, count_only(CELLS)});
        rows.push_back('{mk(CMD_CUT_SPH, 0, 0, 0, 0, 0, 0, 0), 1, count_only(1)});
        rows.push_back('{mk(CMD_PUT_SPH, 31, 0, 31, 0, 0, 0, 31), 0, blank});
        rows.push_back('{mk(CMD_READ, 0, 31, 0), 0, blank});
        rows.push_back('{mk(CMD_PUT_ELL, 10, 20, 30, 0, 0, 0, 0, 0, 0), 1, count_only(1)});
        // one zero axis leaves a flat slice through the centre
        rows.push_back('{mk(CMD_PUT_ELL, 16, 16, 16, 0, 0, 0, 5, 0, 7), 0, blank});
        rows.push_back('{mk(CMD_CUT_ELL, 8, 9, 10, 0, 0, 0, 3, 31, 2), 0, blank});
        rows.push_back('{mk(CMD_READ, 16, 16, 16), 0, blank});
        rows.push_back('{mk(CMD_READ, 8, 9, 10), 0, blank});
        rows.push_back('{mk(CMD_SPARE_LO, 31, 31, 31, 31, 31, 31, 31, 31, 31), 1, blank});
        rows.push_back('{mk(CMD_SPARE_HI, 0, 0, 0), 1, blank});
        foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].rsp);

        lx = 0; ly = 0; lz = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 35) set_colours(8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'd255);
            if (n == 70) set_colours(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if (n % 20 == 0) quiet = ($urandom_range(0, 2) == 0);
            c = mk(4'($urandom_range(0, 15)), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // mostly revisit a recently written voxel
                c.cmd = CMD_READ;
                if ($urandom_range(0, 3) != 0) begin
                    c.xa = 5'(lx + $urandom_range(0, 1));
                    c.ya = 5'(ly);
                    c.za = 5'(lz);
                end
            end else if (pick < 55) begin
                c.cmd = $urandom_range(0, 1) ? CMD_CUT_VOX : CMD_PUT_VOX;
            end else if (pick < 82) begin
                c.cmd = $urandom_range(0, 2) ? CMD_PUT_BOX : CMD_CUT_BOX;
                if ($urandom_range(0, 9) != 0) begin
                    w = $urandom_range(0, 4);
                    c.xb = (int'(c.xa) + w > 31) ? 5'd31 : 5'(int'(c.xa) + w);
                    w = $urandom_range(0, 4);
                    c.yb = (int'(c.ya) + w > 31) ? 5'd31 : 5'(int'(c.ya) + w);
                    w = $urandom_range(0, 4);
                    c.zb = (int'(c.za) + w > 31) ? 5'd31 : 5'(int'(c.za) + w);
                end
            end else if (pick < 88) begin
                c.cmd = 4'(CMD_PUT_SPH + $urandom_range(0, 3));
            end else if (pick < 94) begin
                c.cmd = 4'(CMD_SPARE_LO + $urandom_range(0, 6));
            end
            if (c.cmd != CMD_READ) begin
                lx = int'(c.xa); ly = int'(c.ya); lz = int'(c.za);
            end
            send(c, 0, blank);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_idle();
        $display("sent %0d commands: %0d reads, %0d sphere or ellipsoid sweeps",
                 items_sent, reads_sent, sweeps_sent);
        $display("checked %0d results against the shadow grid, %0d mismatches",
                 results_seen, errors);
        if (errors == 0 && expected_rsp_q.size() == 0)
            $display("voxel_shape_rasterizer_top test passed");
        else
            $display("voxel_shape_rasterizer_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
